[hdl/rbc_pkg.sv]
// shared types, register indexes and fixed-point helpers for the receptor binding step
`default_nettype none
package rbc_pkg;

    localparam int DIV_STEPS = 16;
    localparam int N_ST      = 14;
    localparam int AW        = 5;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_TIME_STEP   = 3'd0,
        REG_BIND_RATE   = 3'd1,
        REG_ENDO_RATE   = 3'd2,
        REG_REL_RATE    = 3'd3,
        REG_RECYC_RATE  = 3'd4,
        REG_SAT_LIMIT   = 3'd5,
        REG_INV_VOLUME  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic               act;
        logic               ok;
        logic [31:0]        eu;
        logic [31:0]        eb;
        logic [31:0]        iu;
        logic [31:0]        ib;
        logic [31:0]        endo;
        logic [31:0]        tot;
        logic [31:0]        rho;
        logic [31:0]        vol;
        logic [15:0]        rnd;
        logic [31:0]        rem;
        logic [16:0]        f;
        logic [31:0]        d;
        logic [31:0]        rv;
        logic [31:0]        alpha;
        logic [31:0]        whole;
        logic               extra;
        logic [47:0]        tdw;
        logic               exf;
        logic [31:0]        ex;
        logic [47:0]        tdx;
        logic [31:0]        prod;
        logic signed [31:0] dd;
    } t_work;

    // q16.16 product, truncated, saturating
    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return (|p[63:48]) ? 32'hFFFF_FFFF : p[47:16];
    endfunction

    function automatic logic [31:0] adds(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] subz(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? (a - b) : 32'd0;
    endfunction

    function automatic logic [31:0] minu(input logic [31:0] a, input logic [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // count to density, not saturated
    function automatic logic [47:0] to_dens(input logic [31:0] a, input logic [31:0] inv);
        logic [63:0] p;
        p = a * inv;
        return p[63:16];
    endfunction

endpackage
`default_nettype wire

[hdl/rbc_div.sv]
// pipelined restoring divider, one quotient bit per stage, for the saturation headroom fraction
`default_nettype none
module rbc_div
    import rbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_rem,
    input  wire logic [31:0] i_den,
    output logic      [15:0] o_quo
);

    logic [31:0] r_rem [DIV_STEPS];
    logic [15:0] r_quo [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        logic [32:0] t;
        logic        ge;
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                t  = (k == 0) ? {i_rem, 1'b0} : {r_rem[k-1], 1'b0};
                ge = (t >= {1'b0, i_den});
                r_rem[k] <= ge ? 32'(t - {1'b0, i_den}) : t[31:0];
                r_quo[k] <= (k == 0) ? {15'd0, ge} : {r_quo[k-1][14:0], ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule
`default_nettype wire

[hdl/receptor_binding_compartment_step.sv]
// top level: receptor binding and trafficking step for one cell record per beat
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_active_cell .. i_random_draw
//  output    out        o_valid / i_stall    o_new_unbound_external .. o_density_change
//  config    in         apb psel / penable   paddr, pwdata, prdata
//
// one beat per cycle sustained while o_stall is low; each beat passes through
// 32 register stages (input stage, 16 divider stages for the headroom fraction,
// 14 multiply/update stages, output register).
// synchronous active-low reset clears valid bits and loads register defaults.
// a two-deep output (register plus skid) holds results; o_stall rises only when both are full.
`default_nettype none
module receptor_binding_compartment_step
    import rbc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_active_cell,
    input  wire logic [31:0]        i_unbound_external,
    input  wire logic [31:0]        i_bound_external,
    input  wire logic [31:0]        i_unbound_internal,
    input  wire logic [31:0]        i_bound_internal,
    input  wire logic [31:0]        i_endosome_load,
    input  wire logic [31:0]        i_total_taken_up,
    input  wire logic signed [31:0] i_local_density,
    input  wire logic [31:0]        i_cell_volume,
    input  wire logic [15:0]        i_random_draw,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [31:0]             o_new_unbound_external,
    output logic [31:0]             o_new_bound_external,
    output logic [31:0]             o_new_unbound_internal,
    output logic [31:0]             o_new_bound_internal,
    output logic [31:0]             o_new_endosome_load,
    output logic [31:0]             o_new_total_taken_up,
    output logic signed [31:0]      o_density_change,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [AW-1:0]      paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic signed [49:0] DD_MAX = 50'sh0000_7FFF_FFFF;
    localparam logic signed [49:0] DD_MIN = -50'sh0000_8000_0000;

    logic [31:0] r_dt, r_br, r_er, r_rr, r_cr, r_sat, r_inv;
    logic [31:0] r_kb, r_ke, r_kr, r_kc;
    t_reg_idx    w_idx;

    t_work       r_a, n_a;
    logic        r_a_v;
    t_work       r_dly [DIV_STEPS];
    logic        r_dly_v [DIV_STEPS];
    t_work       r_st [N_ST];
    logic        r_st_v [N_ST];
    t_work       n_st [N_ST];
    t_work       r_out, r_skid;
    logic        r_out_v, r_skid_v;
    logic        w_en, w_take;
    logic [15:0] w_quo;

    // configuration
    assign w_idx  = t_reg_idx'(paddr[AW-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= 32'd655;
            r_br  <= '0;
            r_er  <= '0;
            r_rr  <= '0;
            r_cr  <= '0;
            r_sat <= 32'd327680;
            r_inv <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_TIME_STEP:  r_dt  <= pwdata;
                REG_BIND_RATE:  r_br  <= pwdata;
                REG_ENDO_RATE:  r_er  <= pwdata;
                REG_REL_RATE:   r_rr  <= pwdata;
                REG_RECYC_RATE: r_cr  <= pwdata;
                REG_SAT_LIMIT:  r_sat <= pwdata;
                REG_INV_VOLUME: r_inv <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TIME_STEP:  prdata = r_dt;
            REG_BIND_RATE:  prdata = r_br;
            REG_ENDO_RATE:  prdata = r_er;
            REG_REL_RATE:   prdata = r_rr;
            REG_RECYC_RATE: prdata = r_cr;
            REG_SAT_LIMIT:  prdata = r_sat;
            REG_INV_VOLUME: prdata = r_inv;
            default:        prdata = '0;
        endcase
    end

    // per-step rate factors, refreshed every cycle from the registers
    always_ff @(posedge i_clk) begin
        r_kb <= mulq(r_dt, r_br);
        r_ke <= mulq(r_dt, r_er);
        r_kr <= mulq(r_dt, r_rr);
        r_kc <= mulq(r_dt, r_cr);
    end

    // pipeline holds only while the skid entry is occupied
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;
    assign w_take  = r_out_v && !i_stall;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
        end
    end

    always_comb begin
        n_a      = '0;
        n_a.act  = i_active_cell;
        n_a.ok   = i_active_cell && (i_local_density > 32'sd0) && (r_sat != 32'd0)
                   && (i_total_taken_up < r_sat);
        n_a.rem  = (i_total_taken_up < r_sat) ? (r_sat - i_total_taken_up) : 32'd0;
        n_a.eu   = i_unbound_external;
        n_a.eb   = i_bound_external;
        n_a.iu   = i_unbound_internal;
        n_a.ib   = i_bound_internal;
        n_a.endo = i_endosome_load;
        n_a.tot  = i_total_taken_up;
        n_a.rho  = i_local_density;
        n_a.vol  = i_cell_volume;
        n_a.rnd  = i_random_draw;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= n_a;
        end
    end

    rbc_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r_a.rem),
        .i_den (r_sat),
        .o_quo (w_quo)
    );

    // record rides alongside the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_dly_v[k] <= 1'b0;
        end else if (w_en) begin
            r_dly_v[0] <= r_a_v;
            for (int k = 1; k < DIV_STEPS; k++) r_dly_v[k] <= r_dly_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= r_a;
            for (int k = 1; k < DIV_STEPS; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    always_comb begin
        logic [31:0]        b;
        logic [31:0]        m;
        logic [31:0]        wh;
        logic signed [49:0] acc;

        // binding mean; with nothing taken up yet the headroom fraction is exactly one
        n_st[0]    = r_dly[DIV_STEPS-1];
        n_st[0].f  = (r_dly[DIV_STEPS-1].tot == 32'd0) ? 17'h1_0000 : {1'b0, w_quo};
        n_st[0].d  = mulq(r_kb, r_dly[DIV_STEPS-1].rho);
        n_st[0].rv = mulq(r_dly[DIV_STEPS-1].rho, r_dly[DIV_STEPS-1].vol);

        n_st[1]   = r_st[0];
        n_st[1].d = mulq(r_st[0].d, r_st[0].vol);

        n_st[2]   = r_st[1];
        n_st[2].d = mulq(r_st[1].d, r_st[1].eu);

        n_st[3]   = r_st[2];
        n_st[3].d = mulq(r_st[2].d, {15'd0, r_st[2].f});

        n_st[4]       = r_st[3];
        n_st[4].alpha = minu(r_st[3].d, r_st[3].rv);

        // stochastic or bulk binding
        n_st[5]       = r_st[4];
        n_st[5].whole = '0;
        n_st[5].extra = 1'b0;
        wh            = minu({r_st[4].alpha[31:16], 16'd0}, r_st[4].eu);
        if (r_st[4].ok && r_st[4].d >= Q_ONE) begin
            n_st[5].whole = wh;
            n_st[5].extra = (r_st[4].rnd <= r_st[4].alpha[15:0])
                            && ((r_st[4].eu - wh) >= Q_ONE);
        end else if (r_st[4].ok && r_st[4].d != 32'd0) begin
            n_st[5].extra = (r_st[4].rnd <= r_st[4].d[15:0]) && (r_st[4].eu >= Q_ONE);
        end

        n_st[6]     = r_st[5];
        b           = r_st[5].whole + (r_st[5].extra ? Q_ONE : 32'd0);
        n_st[6].eu  = r_st[5].eu - b;
        n_st[6].eb  = adds(r_st[5].eb, b);
        n_st[6].tot = adds(r_st[5].tot, b);
        n_st[6].tdw = to_dens(r_st[5].whole, r_inv);

        // give back anything above saturation
        n_st[7]     = r_st[6];
        n_st[7].exf = r_st[6].act && (r_st[6].tot > r_sat);
        n_st[7].ex  = r_st[6].tot - r_sat;
        if (n_st[7].exf) begin
            n_st[7].eu  = adds(r_st[6].eu, n_st[7].ex);
            n_st[7].eb  = subz(r_st[6].eb, n_st[7].ex);
            n_st[7].tot = r_sat;
        end

        n_st[8]      = r_st[7];
        n_st[8].tdx  = r_st[7].exf ? to_dens(r_st[7].ex, r_inv) : 48'd0;
        n_st[8].prod = mulq(r_ke, r_st[7].eb);

        // endocytosis, and the density change total
        n_st[9] = r_st[8];
        acc     = $signed({2'b00, r_st[8].tdx}) - $signed({2'b00, r_st[8].tdw})
                  - (r_st[8].extra ? $signed({18'd0, r_inv}) : 50'sd0);
        if (acc > DD_MAX)      n_st[9].dd = 32'sh7FFF_FFFF;
        else if (acc < DD_MIN) n_st[9].dd = 32'sh8000_0000;
        else                   n_st[9].dd = acc[31:0];
        m = minu(r_st[8].prod, r_st[8].eb);
        if (r_st[8].act) begin
            n_st[9].eb = r_st[8].eb - m;
            n_st[9].ib = adds(r_st[8].ib, m);
        end

        n_st[10]      = r_st[9];
        n_st[10].prod = mulq(r_kr, r_st[9].ib);

        // cargo release
        n_st[11] = r_st[10];
        m        = minu(r_st[10].prod, r_st[10].ib);
        if (r_st[10].act) begin
            n_st[11].ib   = r_st[10].ib - m;
            n_st[11].iu   = adds(r_st[10].iu, m);
            n_st[11].endo = adds(r_st[10].endo, m);
        end

        n_st[12]      = r_st[11];
        n_st[12].prod = mulq(r_kc, r_st[11].iu);

        // recycling
        n_st[13] = r_st[12];
        m        = minu(r_st[12].prod, r_st[12].iu);
        if (r_st[12].act) begin
            n_st[13].iu = r_st[12].iu - m;
            n_st[13].eu = adds(r_st[12].eu, m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ST; k++) r_st_v[k] <= 1'b0;
        end else if (w_en) begin
            r_st_v[0] <= r_dly_v[DIV_STEPS-1];
            for (int k = 1; k < N_ST; k++) r_st_v[k] <= r_st_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ST; k++) r_st[k] <= n_st[k];
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) r_skid_v <= 1'b0;
        end else if (r_st_v[N_ST-1]) begin
            if (!r_out_v || w_take) r_out_v  <= 1'b1;
            else                    r_skid_v <= 1'b1;
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) r_out <= r_skid;
        end else if (r_st_v[N_ST-1]) begin
            if (!r_out_v || w_take) r_out  <= r_st[N_ST-1];
            else                    r_skid <= r_st[N_ST-1];
        end
    end

    assign o_valid                = r_out_v;
    assign o_new_unbound_external = r_out.eu;
    assign o_new_bound_external   = r_out.eb;
    assign o_new_unbound_internal = r_out.iu;
    assign o_new_bound_internal   = r_out.ib;
    assign o_new_endosome_load    = r_out.endo;
    assign o_new_total_taken_up   = r_out.tot;
    assign o_density_change       = r_out.dd;

endmodule
`default_nettype wire

[hdl/rbc_chk.sv]
// port-level checker for the receptor binding step, bound to the top level
`default_nettype none
module rbc_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_stall,
    input wire logic pready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && pready)
        else $error("input stalled while output register empty");

endmodule

bind receptor_binding_compartment_step rbc_chk u_rbc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .pready  (pready)
);
`default_nettype wire

[tb/receptor_binding_compartment_step_test.sv]
// testbench for the receptor binding step: random and directed cell records, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module receptor_binding_compartment_step_test
    import rbc_pkg::*;
();

    typedef struct {
        logic        act;
        logic [31:0] eu, eb, iu, ib, endo, tot, rho, vol;
        logic [15:0] rnd;
    } t_cell;

    typedef struct {
        logic [31:0] eu, eb, iu, ib, endo, tot, dd;
    } t_upd;

    logic [31:0] cfg [7];

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = (a * b) >> 16;
        return p > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : p;
    endfunction

    function automatic logic [63:0] qadd(logic [63:0] a, logic [63:0] b);
        return (a + b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + b;
    endfunction

    function automatic longint dens(logic [63:0] x);
        logic [63:0] p;
        p = (x * {32'd0, cfg[REG_INV_VOLUME]}) >> 16;
        return longint'(p);
    endfunction

    function automatic t_upd step_cell(t_cell c);
        logic [63:0] eu, eb, iu, ib, endo, tot, rho, vol, r, dt, sat;
        logic [63:0] f, d, alpha, whole, frac, m, ex;
        longint dd;
        t_upd u;
        eu = c.eu; eb = c.eb; iu = c.iu; ib = c.ib; endo = c.endo; tot = c.tot;
        rho = c.rho; vol = c.vol; r = c.rnd;
        dt = cfg[REG_TIME_STEP]; sat = cfg[REG_SAT_LIMIT]; dd = 0;
        if (c.act) begin
            if (rho != 0 && !rho[31] && sat != 0 && tot < sat) begin
                f = ((sat - tot) << 16) / sat;
                d = qmul(dt, cfg[REG_BIND_RATE]);
                d = qmul(d, rho); d = qmul(d, vol); d = qmul(d, eu); d = qmul(d, f);
                if (d > 0 && d < 65536) begin
                    if (r <= d && eu >= 65536) begin
                        eu -= 65536; eb = qadd(eb, 65536); tot = qadd(tot, 65536);
                        dd -= dens(65536);
                    end
                end else if (d >= 65536) begin
                    alpha = qmul(rho, vol);
                    if (d < alpha) alpha = d;
                    whole = alpha & ~64'hFFFF;
                    frac = alpha & 64'hFFFF;
                    if (eu < whole) whole = eu;
                    eu -= whole; eb = qadd(eb, whole); tot = qadd(tot, whole);
                    dd -= dens(whole);
                    if (r <= frac && eu >= 65536) begin
                        eu -= 65536; eb = qadd(eb, 65536); tot = qadd(tot, 65536);
                        dd -= dens(65536);
                    end
                end
            end
            if (tot > sat) begin
                ex = tot - sat;
                eu = qadd(eu, ex); eb = eb > ex ? eb - ex : 0; tot = sat;
                dd += dens(ex);
            end
            m = qmul(qmul(dt, cfg[REG_ENDO_RATE]), eb); if (m > eb) m = eb;
            eb -= m; ib = qadd(ib, m);
            m = qmul(qmul(dt, cfg[REG_REL_RATE]), ib); if (m > ib) m = ib;
            ib -= m; iu = qadd(iu, m); endo = qadd(endo, m);
            m = qmul(qmul(dt, cfg[REG_RECYC_RATE]), iu); if (m > iu) m = iu;
            iu -= m; eu = qadd(eu, m);
        end
        if (dd > 64'sd2147483647) dd = 64'sd2147483647;
        if (dd < -64'sd2147483648) dd = -64'sd2147483648;
        u.eu = eu; u.eb = eb; u.iu = iu; u.ib = ib; u.endo = endo; u.tot = tot;
        u.dd = dd[31:0];
        return u;
    endfunction

    class cell_scoreboard;
        t_upd pending[$];
        int   errors;
        int   checked;

        function void note_cell(t_cell c);
            pending.insert(pending.size(), step_cell(c));
        endfunction

        function void field(string nm, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s: expected %h, got %h", nm, e, a);
                errors++;
            end
        endfunction

        function void check_update(t_upd a);
            t_upd e;
            if (pending.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            field("new_unbound_external", e.eu, a.eu);
            field("new_bound_external", e.eb, a.eb);
            field("new_unbound_internal", e.iu, a.iu);
            field("new_bound_internal", e.ib, a.ib);
            field("new_endosome_load", e.endo, a.endo);
            field("new_total_taken_up", e.tot, a.tot);
            field("density_change", e.dd, a.dd);
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic i_active_cell = 0;
    logic [31:0] i_unbound_external = 0, i_bound_external = 0, i_unbound_internal = 0;
    logic [31:0] i_bound_internal = 0, i_endosome_load = 0, i_total_taken_up = 0;
    logic signed [31:0] i_local_density = 0;
    logic [31:0] i_cell_volume = 0;
    logic [15:0] i_random_draw = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [AW-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    wire o_stall, o_valid, pready;
    wire [31:0] prdata, o_new_unbound_external, o_new_bound_external, o_new_unbound_internal;
    wire [31:0] o_new_bound_internal, o_new_endosome_load, o_new_total_taken_up;
    wire signed [31:0] o_density_change;

    receptor_binding_compartment_step uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    cell_scoreboard sb = new();
    int  idle_pct = 36;
    bit  hold_off = 0;
    int  quiet = 0;
    int  fed = 0;

    // receiver: random stall plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 0;
        else i_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_update('{o_new_unbound_external, o_new_bound_external,
                o_new_unbound_internal, o_new_bound_internal, o_new_endosome_load,
                o_new_total_taken_up, o_density_change});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= AW'(4 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cfg[idx] = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(16) << 16;
            3: return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        c.act = $urandom_range(9) != 0;
        c.eu = $urandom_range(3) == 0 ? rand_word() : $urandom_range(64 << 16);
        c.eb = $urandom_range(3) == 0 ? rand_word() : $urandom_range(64 << 16);
        c.iu = $urandom_range(3) == 0 ? rand_word() : $urandom_range(64 << 16);
        c.ib = $urandom_range(3) == 0 ? rand_word() : $urandom_range(64 << 16);
        c.endo = rand_word();
        c.tot = $urandom_range(3) == 0 ? rand_word() : $urandom_range(cfg[REG_SAT_LIMIT] + 65536);
        c.rho = $urandom_range(3) == 0 ? rand_word() : $urandom_range(8 << 16);
        c.vol = $urandom_range(3) == 0 ? rand_word() : $urandom_range(8 << 16);
        c.rnd = $urandom;
        return c;
    endfunction

    task automatic send_cell(t_cell c, bit gaps);
        while (gaps && $urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_active_cell <= c.act;
        i_unbound_external <= c.eu; i_bound_external <= c.eb;
        i_unbound_internal <= c.iu; i_bound_internal <= c.ib;
        i_endosome_load <= c.endo; i_total_taken_up <= c.tot;
        i_local_density <= c.rho; i_cell_volume <= c.vol; i_random_draw <= c.rnd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_cell(c);
        fed++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_setting(int k);
        logic [31:0] v [7];
        case (k)
            0: v = '{32'd655, 32'd0, 32'd0, 32'd0, 32'd0, 32'd327680, 32'd0};
            1: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            3: v = '{32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 32'h0000_2000,
                     32'h0000_1000, 32'h0005_0000, 32'h0000_8000};
            default: begin
                v[0] = $urandom_range(1 << 17); v[1] = $urandom_range(1 << 18);
                v[2] = $urandom_range(65536); v[3] = $urandom_range(65536);
                v[4] = $urandom_range(65536); v[5] = $urandom_range(40 << 16);
                v[6] = $urandom;
            end
        endcase
        for (int i = 0; i < 7; i++) write_reg(t_reg_idx'(i), v[i]);
    endtask

    initial begin
        t_cell c;
        cfg = '{32'd655, 32'd0, 32'd0, 32'd0, 32'd0, 32'd327680, 32'd0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, inactive pass-through, stochastic, bulk, saturation
        load_setting(3);
        for (int k = 0; k < 24; k++) begin
            c = '{1, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                  0, 0, 32'h0001_0000, 32'h0001_0000, 16'h0000};
            case (k)
                0: c.act = 0;
                1: c = '{1, '1, '1, '1, '1, '1, '1, 32'h7FFF_FFFF, '1, 16'hFFFF};
                2: c.rho = 32'h8000_0000;
                3: c.rho = 0;
                4: c.tot = 32'h0005_0000;
                5: c.tot = 32'h0009_0000;
                6: begin c.rho = 32'h0000_0100; c.rnd = 0; end
                7: begin c.rho = 32'h0000_0100; c.rnd = 16'hFFFF; end
                8: begin c.rho = 32'h0000_0100; c.eu = 32'h0000_8000; end
                9: c.tot = 32'h0004_8000;
                10: c.eu = 0;
                11: begin c.rho = 32'h0003_0000; c.vol = 32'h0002_8000; end
                12: c.rnd = 16'hFFFF;
                default: c = rand_cell();
            endcase
            send_cell(c, 0);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 2) begin
                load_setting(1);
            end else if (ph == 3) begin
                load_setting(2);
            end else begin
                load_setting(ph == 0 ? 0 : 4);
            end
            idle_pct = (ph == 5) ? 0 : 36;
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (120) @(posedge i_clk);
                        hold_off = 0;
                    end
                    repeat (240) send_cell(rand_cell(), 0);
                join
            end else begin
                repeat (240) send_cell(rand_cell(), 1);
            end
            drain();
        end

        $display("fed %0d cell records over 9 register settings, %0d updates checked",
            fed, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
